// File: src/slcd_pkg.sv
// shared types and constants for the sync, length and checksum deframer
package slcd_pkg;

   typedef logic [7:0] byte_type;
   typedef logic [2:0] status_type;
   typedef logic [1:0] csr_index_type;

   localparam int CsrDataWidth = 32;

   localparam byte_type SYNC_FIRST  = 8'hFF;
   localparam byte_type SYNC_SECOND = 8'h55;

   localparam logic OP_BYTE = 1'b0;
   localparam logic OP_TICK = 1'b1;

   localparam logic KIND_PAYLOAD = 1'b0;
   localparam logic KIND_STATUS  = 1'b1;

   localparam status_type ST_GOOD     = 3'd0;
   localparam status_type ST_BAD_SUM  = 3'd1;
   localparam status_type ST_TOO_LONG = 3'd2;
   localparam status_type ST_ZERO_LEN = 3'd3;
   localparam status_type ST_TIMEOUT  = 3'd4;
   localparam status_type ST_IDLE     = 3'd5;

   localparam csr_index_type CSR_ENABLED           = 2'd0;
   localparam csr_index_type CSR_MAX_LENGTH        = 2'd1;
   localparam csr_index_type CSR_INTERBYTE_TIMEOUT = 2'd2;
   localparam csr_index_type CSR_SERIAL_TIMEOUT    = 2'd3;

   localparam logic        RESET_ENABLED           = 1'b1;
   localparam byte_type    RESET_MAX_LENGTH        = 8'd255;
   localparam logic [15:0] RESET_INTERBYTE_TIMEOUT = 16'd1000;
   localparam logic [31:0] RESET_SERIAL_TIMEOUT    = 32'd30000;

endpackage

// File: src/slcd_req_if.sv
// input channel: received bytes and time ticks
interface slcd_req_if;
   import slcd_pkg::*;

   logic     valid;
   logic     ready;
   logic     operation;
   byte_type rx_byte;

   modport source (output valid, output operation, output rx_byte, input ready);
   modport sink (input valid, input operation, input rx_byte, output ready);
endinterface

// File: src/slcd_rsp_if.sv
// result channel: payload bytes and packet or line status
interface slcd_rsp_if;
   import slcd_pkg::*;

   logic       valid;
   logic       ready;
   logic       kind;
   byte_type   payload_byte;
   byte_type   byte_index;
   status_type status;
   byte_type   packet_length;

   modport source (output valid, output kind, output payload_byte, output byte_index,
                   output status, output packet_length, input ready);
   modport sink (input valid, input kind, input payload_byte, input byte_index,
                 input status, input packet_length, output ready);
endinterface

// File: src/sync_length_checksum_deframer.sv
// Deframer for small serial packets framed as 0xFF 0x55, length, payload, checksum.
// Each transaction on req is a received byte or one time tick. A new transaction
// can be accepted every clock as long as the result register is empty or being
// drained in the same cycle. Payload bytes leave on rsp as they arrive, each
// tagged with its index; the byte after the payload is checked against the negated
// 8-bit sum of length and payload and closes the packet with a status. A zero or
// over-limit length ends the packet at once. Ticks end a stalled packet with a
// timeout status and report line idle once per quiet period. The consumer is
// expected to drop a packet whose closing status is not good. While disabled,
// received bytes have no effect but ticks are still counted.
module sync_length_checksum_deframer (
   input  logic                            clock,
   input  logic                            reset,
   slcd_req_if.sink                        req,
   slcd_rsp_if.source                      rsp,
   input  logic                            csr_write_enable,
   input  slcd_pkg::csr_index_type         csr_index,
   input  logic [slcd_pkg::CsrDataWidth-1:0] csr_write_data
);
   import slcd_pkg::*;

   // configuration
   logic        enabled_ff;
   byte_type    max_length_ff;
   logic [15:0] interbyte_timeout_ff;
   logic [31:0] serial_timeout_ff;

   // framing state
   byte_type    previous_byte_ff, previous_byte_in;
   logic        in_packet_ff, in_packet_in;
   logic        have_length_ff, have_length_in;
   byte_type    expected_length_ff, expected_length_in;
   byte_type    byte_count_ff, byte_count_in;
   byte_type    running_sum_ff, running_sum_in;
   logic [31:0] quiet_ticks_ff, quiet_ticks_in;
   logic        idle_reported_ff, idle_reported_in;

   // result register
   logic        rsp_valid_ff;
   logic        kind_ff, kind_in;
   byte_type    payload_byte_ff, payload_byte_in;
   byte_type    byte_index_ff, byte_index_in;
   status_type  status_ff, status_in;
   byte_type    packet_length_ff, packet_length_in;

   logic        emit;
   logic        accept;
   logic [31:0] quiet_next;
   byte_type    want_sum;

   assign req.ready = !rsp_valid_ff || rsp.ready;
   assign accept    = req.valid && req.ready;

   assign quiet_next = (quiet_ticks_ff == '1) ? quiet_ticks_ff : quiet_ticks_ff + 32'd1;
   assign want_sum   = 8'd0 - running_sum_ff;

   always_comb begin
      previous_byte_in   = previous_byte_ff;
      in_packet_in       = in_packet_ff;
      have_length_in     = have_length_ff;
      expected_length_in = expected_length_ff;
      byte_count_in      = byte_count_ff;
      running_sum_in     = running_sum_ff;
      quiet_ticks_in     = quiet_ticks_ff;
      idle_reported_in   = idle_reported_ff;
      emit               = 1'b0;
      kind_in            = KIND_STATUS;
      payload_byte_in    = '0;
      byte_index_in      = '0;
      status_in          = ST_GOOD;
      packet_length_in   = '0;

      if (req.operation == OP_TICK) begin
         quiet_ticks_in = quiet_next;
         if (in_packet_ff) begin
            if (quiet_next >= {16'd0, interbyte_timeout_ff}) begin
               in_packet_in     = 1'b0;
               have_length_in   = 1'b0;
               quiet_ticks_in   = '0;
               emit             = 1'b1;
               status_in        = ST_TIMEOUT;
               packet_length_in = have_length_ff ? expected_length_ff : 8'd0;
            end
         end else if (!idle_reported_ff && quiet_next >= serial_timeout_ff) begin
            idle_reported_in = 1'b1;
            emit             = 1'b1;
            status_in        = ST_IDLE;
         end
      end else if (enabled_ff) begin
         quiet_ticks_in   = '0;
         idle_reported_in = 1'b0;
         previous_byte_in = req.rx_byte;
         if (!in_packet_ff) begin
            if (previous_byte_ff == SYNC_FIRST && req.rx_byte == SYNC_SECOND) begin
               in_packet_in       = 1'b1;
               have_length_in     = 1'b0;
               expected_length_in = '0;
               byte_count_in      = '0;
               running_sum_in     = '0;
            end
         end else if (!have_length_ff) begin
            expected_length_in = req.rx_byte;
            // over-limit is tested before zero length
            if (req.rx_byte > max_length_ff) begin
               in_packet_in     = 1'b0;
               emit             = 1'b1;
               status_in        = ST_TOO_LONG;
               packet_length_in = req.rx_byte;
            end else if (req.rx_byte == 8'd0) begin
               in_packet_in     = 1'b0;
               emit             = 1'b1;
               status_in        = ST_ZERO_LEN;
               packet_length_in = req.rx_byte;
            end else begin
               have_length_in = 1'b1;
               byte_count_in  = '0;
               running_sum_in = req.rx_byte;
            end
         end else if (byte_count_ff < expected_length_ff) begin
            emit             = 1'b1;
            kind_in          = KIND_PAYLOAD;
            payload_byte_in  = req.rx_byte;
            byte_index_in    = byte_count_ff;
            packet_length_in = expected_length_ff;
            running_sum_in   = running_sum_ff + req.rx_byte;
            byte_count_in    = byte_count_ff + 8'd1;
         end else begin
            // checksum byte closes the packet
            in_packet_in     = 1'b0;
            have_length_in   = 1'b0;
            emit             = 1'b1;
            status_in        = (want_sum == req.rx_byte) ? ST_GOOD : ST_BAD_SUM;
            packet_length_in = expected_length_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         enabled_ff           <= RESET_ENABLED;
         max_length_ff        <= RESET_MAX_LENGTH;
         interbyte_timeout_ff <= RESET_INTERBYTE_TIMEOUT;
         serial_timeout_ff    <= RESET_SERIAL_TIMEOUT;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            CSR_ENABLED:           enabled_ff           <= csr_write_data[0];
            CSR_MAX_LENGTH:        max_length_ff        <= csr_write_data[7:0];
            CSR_INTERBYTE_TIMEOUT: interbyte_timeout_ff <= csr_write_data[15:0];
            CSR_SERIAL_TIMEOUT:    serial_timeout_ff    <= csr_write_data[31:0];
            default:               enabled_ff           <= enabled_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         previous_byte_ff   <= '0;
         in_packet_ff       <= 1'b0;
         have_length_ff     <= 1'b0;
         expected_length_ff <= '0;
         byte_count_ff      <= '0;
         running_sum_ff     <= '0;
         quiet_ticks_ff     <= '0;
         idle_reported_ff   <= 1'b0;
      end else if (accept) begin
         previous_byte_ff   <= previous_byte_in;
         in_packet_ff       <= in_packet_in;
         have_length_ff     <= have_length_in;
         expected_length_ff <= expected_length_in;
         byte_count_ff      <= byte_count_in;
         running_sum_ff     <= running_sum_in;
         quiet_ticks_ff     <= quiet_ticks_in;
         idle_reported_ff   <= idle_reported_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (accept && emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && emit) begin
         kind_ff          <= kind_in;
         payload_byte_ff  <= payload_byte_in;
         byte_index_ff    <= byte_index_in;
         status_ff        <= status_in;
         packet_length_ff <= packet_length_in;
      end
   end

   assign rsp.valid         = rsp_valid_ff;
   assign rsp.kind          = kind_ff;
   assign rsp.payload_byte  = payload_byte_ff;
   assign rsp.byte_index    = byte_index_ff;
   assign rsp.status        = status_ff;
   assign rsp.packet_length = packet_length_ff;

endmodule

// File: test/testbench.sv
// testbench for the deframer: directed frames, config extremes, backpressure, random traffic
module testbench;
   timeunit 1ns;
   timeprecision 1ps;
   import slcd_pkg::*;

   localparam int unsigned IdleLimit = 2000;
   localparam int unsigned LongHold = 300;
   localparam int unsigned ItemsPerRound = 130;

   typedef struct {
      logic       kind;
      byte_type   payload_byte;
      byte_type   byte_index;
      status_type status;
      byte_type   packet_length;
   } deframer_output_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_write_enable;
   csr_index_type csr_index;
   logic [CsrDataWidth-1:0] csr_write_data;

   slcd_req_if req_bus ();
   slcd_rsp_if rsp_bus ();

   sync_length_checksum_deframer dut (
      .clock            (clock),
      .reset            (reset),
      .req              (req_bus),
      .rsp              (rsp_bus),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   // expected deframer state and configuration
   logic        cfg_enabled;
   byte_type    cfg_max_length;
   logic [15:0] cfg_interbyte;
   logic [31:0] cfg_serial;
   byte_type    last_rx;
   logic        framing;
   logic        length_known;
   byte_type    frame_length;
   byte_type    payload_count;
   byte_type    checksum_acc;
   logic [31:0] quiet_count;
   logic        idle_flagged;

   deframer_output_type awaited_outputs[$];

   int unsigned mismatch_count;
   int unsigned bytes_sent;
   int unsigned ticks_sent;
   int unsigned effective_items;
   int unsigned configs_applied;
   int unsigned payload_seen;
   int unsigned status_seen[8];
   int unsigned long_hold_request;
   bit          idling_on;

   always #10 clock = ~clock;

   function automatic int unsigned pick_gap();
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (!idling_on || roll < 60) return 0;
      if (roll < 93) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // advances the expected state by one accepted transaction
   function automatic void predict_outputs(input logic op, input byte_type data);
      deframer_output_type out;
      bit produced;
      produced = 1'b0;
      out = '{kind: KIND_STATUS, payload_byte: 8'd0, byte_index: 8'd0,
              status: ST_GOOD, packet_length: 8'd0};
      if (op == OP_TICK) begin
         if (quiet_count != 32'hFFFF_FFFF) quiet_count++;
         if (framing) begin
            if (quiet_count >= {16'd0, cfg_interbyte}) begin
               out.status = ST_TIMEOUT;
               out.packet_length = length_known ? frame_length : 8'd0;
               framing = 1'b0;
               length_known = 1'b0;
               quiet_count = 32'd0;
               produced = 1'b1;
            end
         end else if (!idle_flagged && quiet_count >= cfg_serial) begin
            idle_flagged = 1'b1;
            out.status = ST_IDLE;
            produced = 1'b1;
         end
      end else if (cfg_enabled) begin
         quiet_count = 32'd0;
         idle_flagged = 1'b0;
         if (!framing) begin
            if (last_rx == SYNC_FIRST && data == SYNC_SECOND) begin
               framing = 1'b1;
               length_known = 1'b0;
               frame_length = 8'd0;
               payload_count = 8'd0;
               checksum_acc = 8'd0;
            end
         end else if (!length_known) begin
            frame_length = data;
            if (data > cfg_max_length) begin
               framing = 1'b0;
               out.status = ST_TOO_LONG;
               out.packet_length = data;
               produced = 1'b1;
            end else if (data == 8'd0) begin
               framing = 1'b0;
               out.status = ST_ZERO_LEN;
               produced = 1'b1;
            end else begin
               length_known = 1'b1;
               payload_count = 8'd0;
               checksum_acc = data;
            end
         end else if (payload_count < frame_length) begin
            out.kind = KIND_PAYLOAD;
            out.payload_byte = data;
            out.byte_index = payload_count;
            out.packet_length = frame_length;
            produced = 1'b1;
            checksum_acc = checksum_acc + data;
            payload_count = payload_count + 8'd1;
         end else begin
            framing = 1'b0;
            length_known = 1'b0;
            out.status = (byte_type'(8'd0 - checksum_acc) == data) ? ST_GOOD : ST_BAD_SUM;
            out.packet_length = frame_length;
            produced = 1'b1;
         end
         last_rx = data;
      end
      if (produced) awaited_outputs.push_back(out);
   endfunction

   task automatic report_mismatch(input string msg);
      mismatch_count++;
      if (mismatch_count <= 40) $display("%0t ns: %s", $time, msg);
   endtask

   task automatic check_field(input string field, input logic [7:0] got, input logic [7:0] want);
      if (got !== want) report_mismatch($sformatf("%s got %0h, expected %0h", field, got, want));
   endtask

   task automatic send_item(input logic op, input byte_type data);
      int unsigned gap;
      gap = pick_gap();
      if (gap != 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.operation <= op;
      req_bus.rx_byte <= data;
      do @(posedge clock); while (!req_bus.ready);
      if (op == OP_TICK) ticks_sent++;
      else bytes_sent++;
      if (op == OP_TICK || cfg_enabled) effective_items++;
      predict_outputs(op, data);
   endtask

   // sync pair, length, payload; checksum only when the payload is complete and in range
   task automatic send_frame(input byte_type length, input byte_type payload[$],
                             input bit corrupt, input bit sprinkle_ticks);
      byte_type sum;
      sum = length;
      send_item(OP_BYTE, SYNC_FIRST);
      send_item(OP_BYTE, SYNC_SECOND);
      send_item(OP_BYTE, length);
      foreach (payload[i]) begin
         if (sprinkle_ticks && $urandom_range(0, 15) == 0)
            send_item(OP_TICK, byte_type'($urandom));
         send_item(OP_BYTE, payload[i]);
         sum = sum + payload[i];
      end
      if (payload.size() == length && length != 8'd0 && length <= cfg_max_length) begin
         sum = 8'd0 - sum;
         if (corrupt) sum = sum ^ byte_type'($urandom_range(1, 255));
         send_item(OP_BYTE, sum);
      end
   endtask

   task automatic write_register(input csr_index_type idx, input logic [CsrDataWidth-1:0] value);
      @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_index <= idx;
      csr_write_data <= value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      case (idx)
         CSR_ENABLED:           cfg_enabled = value[0];
         CSR_MAX_LENGTH:        cfg_max_length = value[7:0];
         CSR_INTERBYTE_TIMEOUT: cfg_interbyte = value[15:0];
         CSR_SERIAL_TIMEOUT:    cfg_serial = value;
         default: ;
      endcase
   endtask

   task automatic set_config(input logic enabled, input logic [31:0] max_length,
                             input logic [31:0] interbyte, input logic [31:0] serial);
      write_register(CSR_ENABLED, {31'd0, enabled});
      write_register(CSR_MAX_LENGTH, max_length);
      write_register(CSR_INTERBYTE_TIMEOUT, interbyte);
      write_register(CSR_SERIAL_TIMEOUT, serial);
      configs_applied++;
   endtask

   // sender holds off until every expected transaction is back, then lets the block settle
   task automatic drain_results();
      req_bus.valid <= 1'b0;
      while (awaited_outputs.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic send_random_sequence();
      int unsigned pick;
      int unsigned len;
      int unsigned kept;
      byte_type payload[$];
      pick = $urandom_range(0, 99);
      if (pick < 6) begin
         repeat ($urandom_range(1, 4))
            send_item(OP_BYTE, ($urandom_range(0, 3) == 0) ? SYNC_FIRST : byte_type'($urandom));
      end else if (pick < 14) begin
         repeat ($urandom_range(1, 40)) send_item(OP_TICK, byte_type'($urandom));
      end else begin
         pick = $urandom_range(0, 99);
         if (pick < 5) len = 0;
         else if (pick < 10 && cfg_max_length != 8'd255)
            len = $urandom_range(cfg_max_length + 1, 255);
         else if (pick < 12) len = $urandom_range(1, cfg_max_length);
         else len = $urandom_range(1, (cfg_max_length < 12) ? cfg_max_length : 12);
         kept = (len <= cfg_max_length) ? len : 0;
         // now and then a frame stalls partway and is left to time out
         if (kept != 0 && $urandom_range(0, 11) == 0) kept = $urandom_range(0, len - 1);
         for (int i = 0; i < kept; i++) payload.push_back(byte_type'($urandom));
         send_frame(byte_type'(len), payload, $urandom_range(0, 7) == 0, 1'b1);
         if (kept < len && len <= cfg_max_length)
            repeat ($urandom_range(1, 40)) send_item(OP_TICK, byte_type'($urandom));
      end
   endtask

   task automatic test_reset_defaults();
      byte_type payload[$];
      idling_on = 1'b0;
      // sync pair inside the payload is plain data
      payload = {SYNC_FIRST, SYNC_SECOND};
      send_frame(8'd2, payload, 1'b0, 1'b0);
   endtask

   task automatic test_small_limits();
      byte_type payload[$];
      byte_type none[$];
      drain_results();
      idling_on = 1'b1;
      set_config(1'b1, 32'd4, 32'd2, 32'd3);
      send_frame(8'd5, none, 1'b0, 1'b0);
      payload = {8'h80};
      send_frame(8'd1, payload, 1'b1, 1'b0);
      repeat (3) send_item(OP_TICK, 8'h00);
      send_item(OP_BYTE, SYNC_FIRST);
      send_item(OP_BYTE, SYNC_SECOND);
      repeat (2) send_item(OP_TICK, 8'hFF);
   endtask

   task automatic test_zero_limits();
      byte_type none[$];
      drain_results();
      set_config(1'b1, 32'd0, 32'd0, 32'd0);
      send_item(OP_TICK, 8'h00);
      // zero length is not over a zero length limit, so it closes with the zero length status
      send_frame(8'd0, none, 1'b0, 1'b0);
      send_item(OP_BYTE, SYNC_FIRST);
      send_item(OP_BYTE, SYNC_SECOND);
      send_item(OP_TICK, 8'h00);
   endtask

   task automatic test_receiver_backpressure();
      byte_type payload[$];
      drain_results();
      set_config(1'b1, 32'd255, 32'hFFFF, 32'hFFFF_FFFF);
      for (int i = 0; i < 255; i++) payload.push_back(byte_type'($urandom));
      long_hold_request = LongHold;
      send_frame(8'd255, payload, 1'b0, 1'b0);
   endtask

   task automatic test_disabled();
      drain_results();
      set_config(1'b0, 32'd8, 32'd3, 32'd5);
      repeat (30) send_random_sequence();
   endtask

   task automatic test_random_traffic();
      int unsigned first_item;
      for (int round = 0; round < 8; round++) begin
         drain_results();
         idling_on = (round % 3 != 0);
         case (round % 4)
            0: set_config(1'b1, 32'd255, $urandom_range(2, 30), $urandom_range(2, 60));
            1: set_config(1'b1, 32'd1, 32'd1, 32'd1);
            2: set_config(1'b1, $urandom_range(2, 20), 32'hFFFF, 32'hFFFF_FFFF);
            default: set_config(1'b1, $urandom_range(2, 254), $urandom_range(1, 20),
                                $urandom_range(1, 50));
         endcase
         first_item = effective_items;
         while (effective_items - first_item < ItemsPerRound) send_random_sequence();
      end
   endtask

   // receiver: random stalls, plus a long hold-off on request
   initial begin : receiver
      int unsigned stall_left;
      stall_left = 0;
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (reset) begin
            rsp_bus.ready <= 1'b0;
         end else begin
            if (long_hold_request != 0) begin
               stall_left = long_hold_request;
               long_hold_request = 0;
            end else if (stall_left == 0 && idling_on && $urandom_range(0, 3) == 0) begin
               stall_left = pick_gap() + 1;
            end
            if (stall_left != 0) begin
               stall_left--;
               rsp_bus.ready <= 1'b0;
            end else begin
               rsp_bus.ready <= 1'b1;
            end
         end
      end
   end

   always @(posedge clock) begin : check_results
      deframer_output_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (awaited_outputs.size() == 0) begin
            report_mismatch($sformatf("unexpected transaction: kind %0d status %0d",
                                      rsp_bus.kind, rsp_bus.status));
         end else begin
            want = awaited_outputs.pop_front();
            check_field("kind", {7'd0, rsp_bus.kind}, {7'd0, want.kind});
            check_field("payload_byte", rsp_bus.payload_byte, want.payload_byte);
            check_field("byte_index", rsp_bus.byte_index, want.byte_index);
            check_field("status", {5'd0, rsp_bus.status}, {5'd0, want.status});
            check_field("packet_length", rsp_bus.packet_length, want.packet_length);
            if (want.kind == KIND_PAYLOAD) payload_seen++;
            else status_seen[want.status]++;
         end
      end
   end

   // ends the run when neither channel moves a transaction for too long
   initial begin : watchdog
      int unsigned quiet_cycles;
      quiet_cycles = 0;
      while (quiet_cycles < IdleLimit) begin
         @(posedge clock);
         if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
            quiet_cycles = 0;
         else
            quiet_cycles++;
      end
      $display("timeout: no transaction for %0d cycles, %0d results outstanding",
               IdleLimit, awaited_outputs.size());
      $display("Test completed with failures");
      $finish;
   end

   initial begin
      req_bus.valid <= 1'b0;
      req_bus.operation <= OP_BYTE;
      req_bus.rx_byte <= 8'd0;
      csr_write_enable <= 1'b0;
      csr_index <= CSR_ENABLED;
      csr_write_data <= '0;
      cfg_enabled = RESET_ENABLED;
      cfg_max_length = RESET_MAX_LENGTH;
      cfg_interbyte = RESET_INTERBYTE_TIMEOUT;
      cfg_serial = RESET_SERIAL_TIMEOUT;
      last_rx = 8'd0;
      framing = 1'b0;
      length_known = 1'b0;
      frame_length = 8'd0;
      payload_count = 8'd0;
      checksum_acc = 8'd0;
      quiet_count = 32'd0;
      idle_flagged = 1'b0;
      long_hold_request = 0;
      idling_on = 1'b0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      test_reset_defaults();
      test_small_limits();
      test_zero_limits();
      test_receiver_backpressure();
      test_disabled();
      test_random_traffic();
      drain_results();
      repeat (8) @(posedge clock);

      $display("sent %0d bytes and %0d ticks under %0d register settings",
               bytes_sent, ticks_sent, configs_applied);
      $display("checked %0d payload bytes; good %0d, bad sum %0d, too long %0d, zero %0d, %s",
               payload_seen, status_seen[ST_GOOD], status_seen[ST_BAD_SUM],
               status_seen[ST_TOO_LONG], status_seen[ST_ZERO_LEN],
               $sformatf("timeout %0d, idle %0d", status_seen[ST_TIMEOUT], status_seen[ST_IDLE]));
      if (mismatch_count == 0 && awaited_outputs.size() == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule

// File: sync_length_checksum_deframer.f
src/slcd_pkg.sv
src/slcd_req_if.sv
src/slcd_rsp_if.sv
src/sync_length_checksum_deframer.sv
test/testbench.sv
